FILE: src/gcr_pkg.sv
// Shared constants, codes and memory port types of the glyph column renderer.
`timescale 1ns / 1ps
`default_nettype none

package gcr_pkg;

   localparam int FONT_BYTES      = 4096;
   localparam int CHAR_SLOTS      = 128;
   localparam int MAX_GLYPH_WIDTH = 48;

   localparam int FONT_AW = $clog2(FONT_BYTES);
   localparam int SLOT_W  = $clog2(CHAR_SLOTS);

   localparam logic [1:0] MODE_LOAD_BYTE  = 2'd0;
   localparam logic [1:0] MODE_LOAD_ENTRY = 2'd1;
   localparam logic [1:0] MODE_DRAW_POS   = 2'd2;
   localparam logic [1:0] MODE_DRAW_CUR   = 2'd3;

   localparam logic [1:0] CSR_FIRST_CHAR   = 2'd0;
   localparam logic [1:0] CSR_GLYPH_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GAP_WIDTH    = 2'd2;
   localparam logic [1:0] CSR_SPACE_WIDTH  = 2'd3;

   localparam logic [7:0] INVERSE_BITS = 8'hF0;
   localparam logic [7:0] CODE_SPACE   = 8'h20;

   typedef struct packed {
      logic               glyph_we;
      logic [FONT_AW-1:0] glyph_waddr;
      logic [7:0]         glyph_wdata;
      logic               slot_we;
      logic [SLOT_W-1:0]  slot_waddr;
      logic [5:0]         width;
      logic [11:0]        offset;
      logic [FONT_AW-1:0] glyph_raddr;
      logic [SLOT_W-1:0]  slot_raddr;
   } font_req_type;

   typedef struct packed {
      logic [7:0]  glyph_byte;
      logic [5:0]  width;
      logic [11:0] offset;
   } font_rsp_type;

endpackage

`default_nettype wire

FILE: src/gcr_font_store.sv
// Glyph byte memory and per-character width/offset table, registered reads.
`timescale 1ns / 1ps
`default_nettype none

module gcr_font_store
   import gcr_pkg::*;
(
   input  wire logic         clock,
   input  wire font_req_type mem_req,
   output font_rsp_type      mem_rsp
);

   logic [7:0]  glyph_mem [FONT_BYTES];
   logic [5:0]  width_mem [CHAR_SLOTS];
   logic [11:0] offset_mem [CHAR_SLOTS];

   logic [7:0]  glyph_byte_ff;
   logic [5:0]  width_ff;
   logic [11:0] offset_ff;

   always_ff @(posedge clock) begin
      if (mem_req.glyph_we) begin
         glyph_mem[mem_req.glyph_waddr] <= mem_req.glyph_wdata;
      end
      glyph_byte_ff <= glyph_mem[mem_req.glyph_raddr];
   end

   always_ff @(posedge clock) begin
      if (mem_req.slot_we) begin
         width_mem[mem_req.slot_waddr]  <= mem_req.width;
         offset_mem[mem_req.slot_waddr] <= mem_req.offset;
      end
      width_ff  <= width_mem[mem_req.slot_raddr];
      offset_ff <= offset_mem[mem_req.slot_raddr];
   end

   assign mem_rsp.glyph_byte = glyph_byte_ff;
   assign mem_rsp.width      = width_ff;
   assign mem_rsp.offset     = offset_ff;

endmodule

`default_nettype wire

FILE: src/glyph_column_renderer.sv
// Top level: font load, character expansion into screen columns, result register.
//
//   channel | direction | beat
//   req_    | in        | load glyph byte, load char entry, or draw one character
//   rsp_    | out       | one screen column: x, top y, mask, colour, op, cursor, last
//   csr_    | in        | register write, index 0..3, no wait
//
// A glyph draw passes ST_TABLE for the width/offset lookup; each glyph column then passes
// ST_DISPATCH, ST_FETCH, ST_SETTLE and ST_EMIT, and each full column ST_DISPATCH and ST_EMIT,
// as the single glyph memory read port fetches one byte per cycle.
// Reset clears the sequencer and the cursor and sets the registers to defaults; font memories
// hold garbage until loaded. A stalled rsp_ready holds the sequencer in ST_EMIT.
`timescale 1ns / 1ps
`default_nettype none

module glyph_column_renderer
   import gcr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [11:0]        req_mem_addr,
   input  wire logic [7:0]         req_mem_byte,
   input  wire logic [5:0]         req_entry_width,
   input  wire logic [11:0]        req_entry_offset,
   input  wire logic [7:0]         req_char_code,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic [31:0]        req_color,
   input  wire logic [7:0]         req_style,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_col_x,
   output logic signed [15:0]      rsp_top_y,
   output logic [63:0]             rsp_pixel_mask,
   output logic [31:0]             rsp_pixel_color,
   output logic [7:0]              rsp_pixel_op,
   output logic signed [15:0]      rsp_cursor_after,
   output logic                    rsp_last,

   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TABLE,
      ST_DISPATCH,
      ST_FETCH,
      ST_SETTLE,
      ST_EMIT
   } state_type;

   state_type          state_ff;

   logic [7:0]         first_char_ff;
   logic [6:0]         glyph_height_ff;
   logic [3:0]         gap_width_ff;
   logic [5:0]         space_width_ff;

   logic [15:0]        cursor_x_ff;
   logic [15:0]        cursor_y_ff;

   logic [15:0]        x_ff;
   logic [15:0]        y_ff;
   logic [31:0]        color_ff;
   logic [7:0]         style_ff;
   logic               inverse_ff;
   logic [5:0]         w_ff;
   logic [5:0]         total_ff;
   logic [5:0]         n_ff;
   logic [15:0]        cur_ff;
   logic [FONT_AW-1:0] addr_ff;
   logic [3:0]         b_ff;
   logic [2:0]         lane_ff;
   logic               rd_vld_ff;
   logic [63:0]        bits_ff;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_col_x_ff;
   logic [15:0]        rsp_top_y_ff;
   logic [63:0]        rsp_mask_ff;
   logic [31:0]        rsp_color_ff;
   logic [7:0]         rsp_op_ff;
   logic [15:0]        rsp_cursor_ff;
   logic               rsp_last_ff;

   font_req_type       mem_req;
   font_rsp_type       mem_rsp;

   logic               accept;
   logic [6:0]         h_sat;
   logic [63:0]        full_mask;
   logic [3:0]         nb;
   logic [5:0]         sp_sat;
   logic [5:0]         space_adv;
   logic signed [9:0]  code_s;
   logic signed [9:0]  slot_s;
   logic               is_glyph;
   logic [15:0]        draw_x;
   logic [15:0]        draw_y;
   logic               draw_inverse;
   logic [5:0]         tbl_w;
   logic [5:0]         entry_w_sat;
   logic               out_free;
   logic               glyph_col;
   logic [63:0]        glyph_bits;
   logic               col_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign h_sat     = (glyph_height_ff > 7'd64) ? 7'd64 : glyph_height_ff;
   assign full_mask = h_sat[6] ? '1 : ((64'd1 << h_sat[5:0]) - 64'd1);
   assign nb        = 4'((h_sat + 7'd7) >> 3);
   assign sp_sat    = (space_width_ff > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH)
                                                            : space_width_ff;
   assign space_adv = 6'(7'(sp_sat) + 7'(gap_width_ff));

   assign code_s   = {{2{req_char_code[7]}}, req_char_code};
   assign slot_s   = code_s - $signed({2'b00, first_char_ff});
   assign is_glyph = (code_s > $signed({2'b00, CODE_SPACE})) && !slot_s[9]
                     && (slot_s[8:0] < 9'(CHAR_SLOTS));

   assign draw_x       = (req_mode == MODE_DRAW_POS) ? req_pos_x : cursor_x_ff;
   assign draw_y       = (req_mode == MODE_DRAW_POS) ? req_pos_y : cursor_y_ff;
   assign draw_inverse = (req_style & INVERSE_BITS) != 8'h00;

   assign tbl_w       = (mem_rsp.width > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH)
                                                              : mem_rsp.width;
   assign entry_w_sat = (req_entry_width > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH)
                                                                : req_entry_width;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign glyph_col  = n_ff < w_ff;
   assign glyph_bits = bits_ff & full_mask;
   assign col_last   = (7'(n_ff) + 7'd1) == 7'(total_ff);

   always_comb begin
      mem_req.glyph_we    = accept && (req_mode == MODE_LOAD_BYTE)
                            && (13'(req_mem_addr) < 13'(FONT_BYTES));
      mem_req.glyph_waddr = FONT_AW'(req_mem_addr);
      mem_req.glyph_wdata = req_mem_byte;
      mem_req.slot_we     = accept && (req_mode == MODE_LOAD_ENTRY)
                            && (13'(req_mem_addr) < 13'(CHAR_SLOTS));
      mem_req.slot_waddr  = SLOT_W'(req_mem_addr);
      mem_req.width       = entry_w_sat;
      mem_req.offset      = req_entry_offset;
      mem_req.glyph_raddr = addr_ff;
      mem_req.slot_raddr  = slot_s[SLOT_W-1:0];
   end

   gcr_font_store u_font_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_char_ff   <= 8'd32;
         glyph_height_ff <= 7'd8;
         gap_width_ff    <= 4'd1;
         space_width_ff  <= 6'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_CHAR:   first_char_ff   <= csr_wdata;
            CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata[6:0];
            CSR_GAP_WIDTH:    gap_width_ff    <= csr_wdata[3:0];
            CSR_SPACE_WIDTH:  space_width_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_vld_ff) begin
            bits_ff[{lane_ff, 3'b000} +: 8] <= mem_rsp.glyph_byte;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_mode == MODE_DRAW_POS || req_mode == MODE_DRAW_CUR)) begin
                  x_ff        <= draw_x;
                  y_ff        <= draw_y;
                  color_ff    <= req_color;
                  style_ff    <= req_style;
                  inverse_ff  <= draw_inverse;
                  n_ff        <= '0;
                  w_ff        <= '0;
                  cursor_y_ff <= draw_y;
                  if (is_glyph) begin
                     total_ff <= '0;
                     state_ff <= ST_TABLE;
                  end else begin
                     total_ff    <= draw_inverse ? space_adv : 6'd0;
                     cur_ff      <= draw_x + 16'(space_adv);
                     cursor_x_ff <= draw_x + 16'(space_adv);
                     state_ff    <= ST_DISPATCH;
                  end
               end
            end
            ST_TABLE: begin
               w_ff        <= tbl_w;
               total_ff    <= tbl_w + (inverse_ff ? 6'(gap_width_ff) : 6'd0);
               cur_ff      <= x_ff + 16'(tbl_w) + 16'(gap_width_ff);
               cursor_x_ff <= x_ff + 16'(tbl_w) + 16'(gap_width_ff);
               addr_ff     <= FONT_AW'(mem_rsp.offset);
               state_ff    <= ST_DISPATCH;
            end
            ST_DISPATCH: begin
               if (n_ff == total_ff) begin
                  state_ff <= ST_IDLE;
               end else if (glyph_col) begin
                  b_ff     <= '0;
                  bits_ff  <= '0;
                  state_ff <= ST_FETCH;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_FETCH: begin
               if (b_ff < nb) begin
                  addr_ff   <= addr_ff + FONT_AW'(1);
                  b_ff      <= b_ff + 4'd1;
                  lane_ff   <= b_ff[2:0];
                  rd_vld_ff <= 1'b1;
                  if ((b_ff + 4'd1) == nb) begin
                     state_ff <= ST_SETTLE;
                  end
               end else begin
                  state_ff <= ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_col_x_ff  <= x_ff + 16'(n_ff);
                  rsp_top_y_ff  <= y_ff;
                  rsp_cursor_ff <= cur_ff;
                  rsp_last_ff   <= col_last;
                  if (glyph_col && inverse_ff) begin
                     rsp_mask_ff  <= ~glyph_bits & full_mask;
                     rsp_color_ff <= '0;
                     rsp_op_ff    <= '0;
                  end else if (glyph_col) begin
                     rsp_mask_ff  <= glyph_bits;
                     rsp_color_ff <= color_ff;
                     rsp_op_ff    <= style_ff;
                  end else begin
                     rsp_mask_ff  <= full_mask;
                     rsp_color_ff <= color_ff;
                     rsp_op_ff    <= '0;
                  end
                  n_ff     <= n_ff + 6'd1;
                  state_ff <= ST_DISPATCH;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_col_x        = $signed(rsp_col_x_ff);
   assign rsp_top_y        = $signed(rsp_top_y_ff);
   assign rsp_pixel_mask   = rsp_mask_ff;
   assign rsp_pixel_color  = rsp_color_ff;
   assign rsp_pixel_op     = rsp_op_ff;
   assign rsp_cursor_after = $signed(rsp_cursor_ff);
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_rd_from_fetch: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_FETCH))
      else $error("glyph byte returned without a fetch");

   a_lane_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (4'(lane_ff) < nb))
      else $error("glyph byte lane beyond column height");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (n_ff <= total_ff))
      else $error("column count ran past total");

   a_emit_only_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_EMIT))
      else $error("column left emit while result register full");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/column_checker.sv
// Column checker: predicts the columns of every draw beat and compares each response beat.
`timescale 1ns / 1ps

module column_checker
   import gcr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [11:0]        req_mem_addr,
   input  wire logic [7:0]         req_mem_byte,
   input  wire logic [5:0]         req_entry_width,
   input  wire logic [11:0]        req_entry_offset,
   input  wire logic [7:0]         req_char_code,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic [31:0]        req_color,
   input  wire logic [7:0]         req_style,

   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [15:0] rsp_col_x,
   input  wire logic signed [15:0] rsp_top_y,
   input  wire logic [63:0]        rsp_pixel_mask,
   input  wire logic [31:0]        rsp_pixel_color,
   input  wire logic [7:0]         rsp_pixel_op,
   input  wire logic signed [15:0] rsp_cursor_after,
   input  wire logic               rsp_last,

   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_wdata,

   output int unsigned             columns_pending,
   output int unsigned             mismatches
);

   typedef struct {
      logic signed [15:0] col_x;
      logic signed [15:0] top_y;
      logic [63:0]        pixel_mask;
      logic [31:0]        pixel_color;
      logic [7:0]         pixel_op;
      logic signed [15:0] cursor_after;
      logic               last;
   } column_t;

   column_t     columns_due[$];
   logic [7:0]  font_bytes [FONT_BYTES];
   logic [5:0]  glyph_widths [CHAR_SLOTS];
   logic [11:0] glyph_offsets [CHAR_SLOTS];
   logic [15:0] cursor_x;
   logic [15:0] cursor_y;
   logic [7:0]  first_code;
   logic [6:0]  glyph_rows;
   logic [3:0]  gap_cols;
   logic [5:0]  space_cols;
   int unsigned error_count = 0;

   task automatic queue_column(input logic [15:0] cx, input logic [15:0] ty,
                               input logic [63:0] mask, input logic [31:0] color,
                               input logic [7:0] op, input logic [15:0] cur, input logic lst);
      column_t c;
      c.col_x        = cx;
      c.top_y        = ty;
      c.pixel_mask   = mask;
      c.pixel_color  = color;
      c.pixel_op     = op;
      c.cursor_after = cur;
      c.last         = lst;
      columns_due.push_back(c);
   endtask

   task automatic render_char(input logic [1:0] mode, input logic [7:0] code,
                              input logic [15:0] px, input logic [15:0] py,
                              input logic [31:0] color, input logic [7:0] style);
      logic [15:0] x0;
      logic [15:0] y0;
      logic [15:0] cur;
      logic [63:0] full;
      logic [63:0] bits;
      logic        inverse;
      int          rows, nb, w, gap, sp, c, slot, total, n;
      int unsigned off;
      x0      = (mode == MODE_DRAW_POS) ? px : cursor_x;
      y0      = (mode == MODE_DRAW_POS) ? py : cursor_y;
      inverse = (style & INVERSE_BITS) != 8'd0;
      rows    = (glyph_rows > 64) ? 64 : glyph_rows;
      full    = (rows >= 64) ? '1 : ((64'd1 << rows) - 64'd1);
      gap     = gap_cols;
      sp      = (space_cols > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : space_cols;
      c       = int'($signed(code));
      slot    = c - int'(first_code);
      n       = 0;
      if (c > int'(CODE_SPACE) && slot >= 0 && slot < CHAR_SLOTS) begin
         w     = (glyph_widths[slot] > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : glyph_widths[slot];
         off   = glyph_offsets[slot];
         nb    = (rows + 7) / 8;
         cur   = 16'(x0 + w + gap);
         total = w + (inverse ? gap : 0);
         for (int ix = 0; ix < w; ix++) begin
            bits = '0;
            for (int b = 0; b < nb; b++)
               bits |= {56'd0, font_bytes[(off + ix * nb + b) % FONT_BYTES]} << (8 * b);
            bits &= full;
            n++;
            if (inverse)
               queue_column(16'(x0 + ix), y0, ~bits & full, '0, '0, cur, n == total);
            else
               queue_column(16'(x0 + ix), y0, bits, color, style, cur, n == total);
         end
         if (inverse) begin
            for (int g = 0; g < gap; g++) begin
               n++;
               queue_column(16'(x0 + w + g), y0, full, color, '0, cur, n == total);
            end
         end
      end else begin
         total = sp + gap;
         cur   = 16'(x0 + total);
         if (inverse) begin
            for (int g = 0; g < total; g++)
               queue_column(16'(x0 + g), y0, full, color, '0, cur, g + 1 == total);
         end
      end
      cursor_x = cur;
      cursor_y = y0;
   endtask

   task automatic check_column(input column_t seen);
      column_t want;
      if (columns_due.size() == 0) begin
         $error("column x %0d y %0d arrived with no column pending", seen.col_x, seen.top_y);
         error_count++;
      end else begin
         want = columns_due.pop_front();
         if (seen.col_x !== want.col_x) begin
            $error("col_x: expected %0d, got %0d", want.col_x, seen.col_x);
            error_count++;
         end
         if (seen.top_y !== want.top_y) begin
            $error("top_y: expected %0d, got %0d", want.top_y, seen.top_y);
            error_count++;
         end
         if (seen.pixel_mask !== want.pixel_mask) begin
            $error("pixel_mask: expected %h, got %h", want.pixel_mask, seen.pixel_mask);
            error_count++;
         end
         if (seen.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %h, got %h", want.pixel_color, seen.pixel_color);
            error_count++;
         end
         if (seen.pixel_op !== want.pixel_op) begin
            $error("pixel_op: expected %h, got %h", want.pixel_op, seen.pixel_op);
            error_count++;
         end
         if (seen.cursor_after !== want.cursor_after) begin
            $error("cursor_after: expected %0d, got %0d", want.cursor_after, seen.cursor_after);
            error_count++;
         end
         if (seen.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, seen.last);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      column_t seen;
      if (reset) begin
         columns_due.delete();
         cursor_x   = '0;
         cursor_y   = '0;
         first_code = CODE_SPACE;
         glyph_rows = 7'd8;
         gap_cols   = 4'd1;
         space_cols = 6'd3;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.col_x        = rsp_col_x;
            seen.top_y        = rsp_top_y;
            seen.pixel_mask   = rsp_pixel_mask;
            seen.pixel_color  = rsp_pixel_color;
            seen.pixel_op     = rsp_pixel_op;
            seen.cursor_after = rsp_cursor_after;
            seen.last         = rsp_last;
            check_column(seen);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_CHAR:   first_code = csr_wdata;
               CSR_GLYPH_HEIGHT: glyph_rows = csr_wdata[6:0];
               CSR_GAP_WIDTH:    gap_cols   = csr_wdata[3:0];
               CSR_SPACE_WIDTH:  space_cols = csr_wdata[5:0];
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_mode)
               MODE_LOAD_BYTE: font_bytes[req_mem_addr] = req_mem_byte;
               MODE_LOAD_ENTRY: begin
                  if (req_mem_addr < CHAR_SLOTS) begin
                     glyph_widths[req_mem_addr[SLOT_W-1:0]] =
                        (req_entry_width > MAX_GLYPH_WIDTH) ? 6'(MAX_GLYPH_WIDTH) : req_entry_width;
                     glyph_offsets[req_mem_addr[SLOT_W-1:0]] = req_entry_offset;
                  end
               end
               default: render_char(req_mode, req_char_code, req_pos_x, req_pos_y,
                                    req_color, req_style);
            endcase
         end
      end
      columns_pending <= columns_due.size();
      mismatches      <= error_count;
   end

endmodule

FILE: tb/sv/glyph_column_renderer_test.sv
// Testbench top: font loads and character draws into the glyph column renderer, and the verdict.
`timescale 1ns / 1ps

module glyph_column_renderer_test;
   import gcr_pkg::*;

   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int DRAIN_CYCLES       = 150;
   localparam int PHASE_ITEMS        = 48;
   localparam int FIXED_PHASES       = 6;
   localparam int LAST_POSITIVE_CODE = 127;

   localparam logic [7:0] PHASE_FIRST [FIXED_PHASES] = '{8'd0, 8'd255, 8'd20, 8'd33, 8'd40, 8'd100};
   localparam logic [7:0] PHASE_ROWS  [FIXED_PHASES] = '{8'd1, 8'd64, 8'hC5, 8'd16, 8'd0, 8'd24};
   localparam logic [7:0] PHASE_GAP   [FIXED_PHASES] = '{8'd0, 8'd15, 8'hF7, 8'd2, 8'd3, 8'd1};
   localparam logic [7:0] PHASE_SPACE [FIXED_PHASES] = '{8'd0, 8'd48, 8'hFF, 8'd5, 8'd10, 8'd49};

   typedef struct {
      logic [1:0]  mode;
      logic [11:0] mem_addr;
      logic [7:0]  mem_byte;
      logic [5:0]  entry_width;
      logic [11:0] entry_offset;
      logic [7:0]  char_code;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [31:0] color;
      logic [7:0]  style;
   } char_req_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [1:0]          req_mode         = MODE_LOAD_BYTE;
   logic [11:0]         req_mem_addr     = '0;
   logic [7:0]          req_mem_byte     = '0;
   logic [5:0]          req_entry_width  = '0;
   logic [11:0]         req_entry_offset = '0;
   logic [7:0]          req_char_code    = '0;
   logic signed [15:0]  req_pos_x        = '0;
   logic signed [15:0]  req_pos_y        = '0;
   logic [31:0]         req_color        = '0;
   logic [7:0]          req_style        = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic signed [15:0]  rsp_col_x;
   logic signed [15:0]  rsp_top_y;
   logic [63:0]         rsp_pixel_mask;
   logic [31:0]         rsp_pixel_color;
   logic [7:0]          rsp_pixel_op;
   logic signed [15:0]  rsp_cursor_after;
   logic                rsp_last;
   logic                csr_we           = 1'b0;
   logic [1:0]          csr_index        = CSR_FIRST_CHAR;
   logic [7:0]          csr_wdata        = '0;
   int unsigned         columns_pending;
   int unsigned         mismatches;

   bit                  byte_loaded [FONT_BYTES];
   bit                  slot_loaded [CHAR_SLOTS];
   logic [5:0]          slot_width [CHAR_SLOTS];
   logic [11:0]         slot_offset [CHAR_SLOTS];
   logic [7:0]          cfg_first = CODE_SPACE;
   logic [6:0]          cfg_rows  = 7'd8;
   bit                  steady = 1'b0;
   int unsigned         items_sent = 0;
   int unsigned         quiet_cycles = 0;

   glyph_column_renderer dut (.*);

   column_checker column_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin : receiver
      int stall;
      int hold;
      stall = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            receiver.hold = stall - 1;
         end
      end else if (!rsp_ready) begin
         if (receiver.hold == 0) rsp_ready <= 1'b1;
         else receiver.hold = receiver.hold - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic int bytes_per_column();
      int rows;
      rows = (cfg_rows > 64) ? 64 : cfg_rows;
      return (rows + 7) / 8;
   endfunction

   function automatic bit draw_safe(input logic [7:0] code);
      int c, slot, nb, w;
      c    = int'($signed(code));
      slot = c - int'(cfg_first);
      if (c <= int'(CODE_SPACE) || slot < 0 || slot >= CHAR_SLOTS) return 1'b1;
      if (!slot_loaded[slot]) return 1'b0;
      nb = bytes_per_column();
      w  = (slot_width[slot] > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : slot_width[slot];
      for (int k = 0; k < w * nb; k++)
         if (!byte_loaded[(slot_offset[slot] + k) % FONT_BYTES]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int pick_glyph_code();
      int code;
      for (int t = 0; t < 32; t++) begin
         code = int'(cfg_first) + $urandom_range(0, CHAR_SLOTS - 1);
         if (code > int'(CODE_SPACE) && code <= LAST_POSITIVE_CODE && draw_safe(8'(code)))
            return code;
      end
      return -1;
   endfunction

   function automatic char_req_type noise_item();
      char_req_type it;
      it.mode         = 2'($urandom);
      it.mem_addr     = 12'($urandom);
      it.mem_byte     = 8'($urandom);
      it.entry_width  = 6'($urandom);
      it.entry_offset = 12'($urandom);
      it.char_code    = 8'($urandom);
      it.pos_x        = 16'($urandom);
      it.pos_y        = 16'($urandom);
      it.color        = $urandom;
      it.style        = 8'($urandom);
      return it;
   endfunction

   task automatic send_item(input char_req_type it);
      int gap_cycles;
      gap_cycles = steady ? 0 : $urandom_range(0, 6);
      if (gap_cycles != 0) begin
         req_valid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= it.mode;
      req_mem_addr     <= it.mem_addr;
      req_mem_byte     <= it.mem_byte;
      req_entry_width  <= it.entry_width;
      req_entry_offset <= it.entry_offset;
      req_char_code    <= it.char_code;
      req_pos_x        <= it.pos_x;
      req_pos_y        <= it.pos_y;
      req_color        <= it.color;
      req_style        <= it.style;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (it.mode == MODE_LOAD_BYTE) begin
         byte_loaded[it.mem_addr] = 1'b1;
      end else if (it.mode == MODE_LOAD_ENTRY && it.mem_addr < CHAR_SLOTS) begin
         slot_loaded[it.mem_addr] = 1'b1;
         slot_width[it.mem_addr]  = it.entry_width;
         slot_offset[it.mem_addr] = it.entry_offset;
      end
      if (!(it.mode == MODE_LOAD_ENTRY && it.mem_addr >= CHAR_SLOTS)) items_sent++;
   endtask

   task automatic load_byte(input logic [11:0] addr, input logic [7:0] value);
      char_req_type it;
      it          = noise_item();
      it.mode     = MODE_LOAD_BYTE;
      it.mem_addr = addr;
      it.mem_byte = value;
      send_item(it);
   endtask

   task automatic load_entry(input logic [11:0] slot, input logic [5:0] w,
                             input logic [11:0] off);
      char_req_type it;
      it              = noise_item();
      it.mode         = MODE_LOAD_ENTRY;
      it.mem_addr     = slot;
      it.entry_width  = w;
      it.entry_offset = off;
      send_item(it);
   endtask

   task automatic draw_char(input logic [1:0] mode, input logic [7:0] code,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [31:0] color, input logic [7:0] style);
      char_req_type it;
      it           = noise_item();
      it.mode      = mode;
      it.char_code = code;
      it.pos_x     = x;
      it.pos_y     = y;
      it.color     = color;
      it.style     = style;
      send_item(it);
   endtask

   task automatic build_glyph();
      int          code, slot, nb, w, cols;
      logic [11:0] off;
      code = $urandom_range(int'(CODE_SPACE) + 1, LAST_POSITIVE_CODE);
      slot = code - int'(cfg_first);
      if (slot < 0 || slot >= CHAR_SLOTS) slot = $urandom_range(0, CHAR_SLOTS - 1);
      nb = bytes_per_column();
      if (nb <= 1 && $urandom_range(0, 9) == 0)
         w = $urandom_range(MAX_GLYPH_WIDTH + 1, 63);
      else
         w = $urandom_range(0, nb == 0 ? 16 : (nb == 1 ? 6 : (nb < 4 ? 3 : 2)));
      off  = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(FONT_BYTES - 16, FONT_BYTES - 1))
                                        : 12'($urandom);
      cols = (w > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : w;
      load_entry(12'(slot), 6'(w), off);
      for (int k = 0; k < cols * nb; k++)
         load_byte(12'((off + k) % FONT_BYTES), 8'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (columns_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(input logic [7:0] first, input logic [7:0] rows,
                                input logic [7:0] gap, input logic [7:0] space);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_CHAR;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= CSR_GLYPH_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= CSR_GAP_WIDTH;
      csr_wdata <= gap;
      @(posedge clock);
      csr_index <= CSR_SPACE_WIDTH;
      csr_wdata <= space;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_first = first;
      cfg_rows  = rows[6:0];
   endtask

   task automatic run_phase(input int quota);
      int unsigned  start;
      int           r, code;
      char_req_type it;
      logic [15:0]  x;
      logic [7:0]   style;
      start = items_sent;
      while (items_sent - start < quota) begin
         if ($urandom_range(0, 39) == 0) steady = !steady;
         r = $urandom_range(0, 99);
         if (r < 10) begin
            build_glyph();
         end else if (r < 20) begin
            it      = noise_item();
            it.mode = ($urandom_range(0, 1) == 0) ? MODE_LOAD_BYTE : MODE_LOAD_ENTRY;
            send_item(it);
         end else if (r < 23) begin
            settle();
         end else begin
            code = ($urandom_range(0, 99) < 65) ? pick_glyph_code() : int'($urandom_range(0, 255));
            if (code < 0 || !draw_safe(8'(code))) code = $urandom_range(0, CODE_SPACE);
            x     = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(32700, 32767)) : 16'($urandom);
            style = 8'($urandom);
            if ($urandom_range(0, 1) == 0) style = style & ~INVERSE_BITS;
            draw_char(($urandom_range(0, 9) < 4) ? MODE_DRAW_POS : MODE_DRAW_CUR, 8'(code),
                      x, 16'($urandom), $urandom, style);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      load_entry(12'd1, 6'd3, 12'd4094);
      load_byte(12'd4094, 8'hFF);
      load_byte(12'd4095, 8'h00);
      load_byte(12'd0, 8'hA5);
      load_entry(12'd4095, 6'd63, 12'd4095);
      load_entry(12'd2, 6'd0, 12'd0);
      load_entry(12'd127, 6'd63, 12'd0);
      draw_char(MODE_DRAW_POS, 8'd33, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 8'h01);
      draw_char(MODE_DRAW_CUR, 8'd33, '0, '0, 32'h0, 8'hF0);
      draw_char(MODE_DRAW_CUR, CODE_SPACE, '0, '0, 32'h1234_5678, 8'h00);
      draw_char(MODE_DRAW_CUR, CODE_SPACE, '0, '0, 32'h8765_4321, 8'hFF);
      draw_char(MODE_DRAW_POS, 8'h80, 16'h8000, 16'h7FFF, 32'hA5A5_5A5A, 8'h10);
      draw_char(MODE_DRAW_CUR, 8'hFF, '0, '0, 32'h0F0F_F0F0, 8'h0F);
      draw_char(MODE_DRAW_CUR, 8'd34, '0, '0, 32'h1, 8'h00);
      draw_char(MODE_DRAW_CUR, 8'd34, '0, '0, 32'h2, 8'h80);
      draw_char(MODE_DRAW_CUR, 8'd0, '0, '0, 32'h3, 8'h20);

      for (int p = 0; p <= FIXED_PHASES; p++) begin
         settle();
         steady = (p == 3);
         if (p < FIXED_PHASES)
            set_registers(PHASE_FIRST[p], PHASE_ROWS[p], PHASE_GAP[p], PHASE_SPACE[p]);
         else
            set_registers(8'($urandom_range(0, 64)), 8'($urandom), 8'($urandom), 8'($urandom));
         run_phase(PHASE_ITEMS);
      end

      steady = 1'b0;
      settle();
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
